>>> hw/rtl/pfe_pkg.sv
package pfe_pkg;

  // Palette geometry
  localparam int PALETTE_ENTRIES = 256;
  localparam int ADDR_W          = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam int COMP_W          = 6;
  localparam int COLOR_W         = 3 * COMP_W;
  localparam int IDX_W           = 8;
  localparam int CNT_W           = 9;

  // Operation codes carried in the mode field
  typedef enum logic [2:0] {
    OP_WR_TARGET = 3'd0,
    OP_WR_GAMMA  = 3'd1,
    OP_WR_DISP   = 3'd2,
    OP_RD_TARGET = 3'd3,
    OP_RD_DISP   = 3'd4,
    OP_FADE      = 3'd5,
    OP_BLACK     = 3'd6,
    OP_COPY      = 3'd7
  } op_t;

  // Result of stepping one palette entry during a sweep
  typedef struct packed {
    logic [COLOR_W-1:0] disp;
    logic [COLOR_W-1:0] targ;
    logic               moved;
    logic               settled;
  } step_res_t;

  // Fixed gamma curve for target writes
  localparam logic [COMP_W-1:0] GAMMA_LUT [64] = '{
    6'd0,  6'd10, 6'd14, 6'd17, 6'd19, 6'd21, 6'd23, 6'd24,
    6'd26, 6'd27, 6'd28, 6'd29, 6'd31, 6'd32, 6'd33, 6'd34,
    6'd35, 6'd36, 6'd37, 6'd37, 6'd38, 6'd39, 6'd40, 6'd41,
    6'd41, 6'd42, 6'd43, 6'd44, 6'd44, 6'd45, 6'd46, 6'd46,
    6'd47, 6'd48, 6'd48, 6'd49, 6'd49, 6'd50, 6'd51, 6'd51,
    6'd52, 6'd52, 6'd53, 6'd53, 6'd54, 6'd54, 6'd55, 6'd55,
    6'd56, 6'd56, 6'd57, 6'd57, 6'd58, 6'd58, 6'd59, 6'd59,
    6'd60, 6'd60, 6'd61, 6'd61, 6'd62, 6'd62, 6'd63, 6'd63
  };

endpackage

>>> hw/rtl/pfe_ram.sv
module pfe_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/pfe_step.sv
module pfe_step (
  input  pfe_pkg::op_t                  op,
  input  logic [pfe_pkg::COLOR_W-1:0]   disp,
  input  logic [pfe_pkg::COLOR_W-1:0]   targ,
  output pfe_pkg::step_res_t            res
);

  logic [pfe_pkg::COMP_W-1:0] d [3];
  logic [pfe_pkg::COMP_W-1:0] t [3];
  logic [pfe_pkg::COMP_W-1:0] nd [3];
  logic [pfe_pkg::COMP_W-1:0] nt [3];
  logic [2:0]                 settled_c;

  // Step each component on its own
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      d[c] = disp[c*pfe_pkg::COMP_W +: pfe_pkg::COMP_W];
      t[c] = targ[c*pfe_pkg::COMP_W +: pfe_pkg::COMP_W];
      nd[c] = d[c];
      nt[c] = t[c];
      settled_c[c] = 1'b0;
      case (op)
        pfe_pkg::OP_FADE: begin
          if (d[c] < t[c]) begin
            nd[c] = d[c] + 6'd1;
          end else if (d[c] > t[c]) begin
            nd[c] = d[c] - 6'd1;
          end
          settled_c[c] = (d[c] == t[c]);
        end
        pfe_pkg::OP_BLACK: begin
          if (d[c] != '0) begin
            nd[c] = d[c] - 6'd1;
            nt[c] = d[c] - 6'd1;
          end
          settled_c[c] = (d[c] == '0);
        end
        default: begin
          nd[c] = t[c];
        end
      endcase
    end
  end

  // Pack the new entry and its flags
  always_comb begin
    res.disp    = {nd[2], nd[1], nd[0]};
    res.targ    = {nt[2], nt[1], nt[0]};
    res.moved   = ({nd[2], nd[1], nd[0]} != disp);
    res.settled = &settled_c;
  end

endmodule

>>> hw/rtl/palette_fade_engine_top.sv
// Channel  Dir  Width  Contents (lowest bit first)
// s_*      in   32+4   tdata: entry_index, red_in, green_in, blue_in; tuser: mode, query_done
// m_*      out  32     tdata: red_out, green_out, blue_out, changed_entries, fade_done
//
// Writes go from transfer to result through ST_FINISH, reads through ST_RDWAIT and ST_FINISH;
// a fade tick, black tick or copy sweeps all PALETTE_ENTRIES entries, one entry a cycle,
// through the single read port of each palette RAM, then passes ST_DRAIN and ST_FINISH.
// One item is in work at a time; s_tready is high only while idle.
// After rst the block sweeps both RAMs to zero, entry by entry, before the first
// transfer. A held result stalls only the final load of the next result.
module palette_fade_engine_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // entry_index[7:0], red_in[13:8], green_in[19:14], blue_in[25:20]
  input  logic [3:0]  s_tuser,   // mode[2:0], query_done[3]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // red[5:0], green[11:6], blue[17:12], changed[26:18], done[27]
);

  localparam logic [pfe_pkg::ADDR_W-1:0] LAST_ADDR =
    pfe_pkg::ADDR_W'(pfe_pkg::PALETTE_ENTRIES - 1);

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_SWEEP  = 6'b000100,
    ST_DRAIN  = 6'b001000,
    ST_RDWAIT = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

  state_t state;

  // Input fields
  pfe_pkg::op_t                  in_op;
  logic                          in_query;
  logic [pfe_pkg::IDX_W-1:0]     in_idx;
  logic [pfe_pkg::COLOR_W-1:0]   in_color;
  logic [pfe_pkg::COLOR_W-1:0]   in_gamma;
  logic                          in_ok;
  logic                          accept;

  // Item held for the duration of the operation
  pfe_pkg::op_t                  op_q;
  logic                          query_q;
  logic                          ok_q;

  // Sweep control
  logic [pfe_pkg::ADDR_W-1:0]    clr_addr;
  logic [pfe_pkg::ADDR_W-1:0]    sweep_addr;
  logic [pfe_pkg::ADDR_W-1:0]    proc_addr;
  logic                          proc_v;
  logic [pfe_pkg::CNT_W-1:0]     changed_cnt;
  logic                          all_settled;
  logic                          done_flag;
  logic                          done_now;
  logic                          is_tick;

  // Result registers
  logic [pfe_pkg::COLOR_W-1:0]   rd_data;
  logic [pfe_pkg::COLOR_W-1:0]   out_rgb;
  logic [pfe_pkg::CNT_W-1:0]     out_cnt;
  logic                          out_done;
  logic                          out_load;

  // RAM ports
  logic                          targ_we;
  logic                          disp_we;
  logic [pfe_pkg::ADDR_W-1:0]    waddr;
  logic [pfe_pkg::COLOR_W-1:0]   targ_wdata;
  logic [pfe_pkg::COLOR_W-1:0]   disp_wdata;
  logic [pfe_pkg::ADDR_W-1:0]    raddr;
  logic [pfe_pkg::COLOR_W-1:0]   targ_rdata;
  logic [pfe_pkg::COLOR_W-1:0]   disp_rdata;
  pfe_pkg::step_res_t            step_res;

  // Unpack the input transfer
  assign in_op    = pfe_pkg::op_t'(s_tuser[2:0]);
  assign in_query = s_tuser[3];
  assign in_idx   = s_tdata[7:0];
  assign in_color = s_tdata[25:8];
  assign in_ok    = (int'(in_idx) < pfe_pkg::PALETTE_ENTRIES);
  assign in_gamma = {pfe_pkg::GAMMA_LUT[s_tdata[25:20]],
                     pfe_pkg::GAMMA_LUT[s_tdata[19:14]],
                     pfe_pkg::GAMMA_LUT[s_tdata[13:8]]};

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_load = (state == ST_FINISH) && (!m_tvalid || m_tready);
  assign is_tick  = (op_q == pfe_pkg::OP_FADE) || (op_q == pfe_pkg::OP_BLACK);
  assign done_now = is_tick ? all_settled : done_flag;

  pfe_ram #(
    .WIDTH (pfe_pkg::COLOR_W),
    .DEPTH (pfe_pkg::PALETTE_ENTRIES)
  ) u_target_ram (
    .clk   (clk),
    .we    (targ_we),
    .waddr (waddr),
    .wdata (targ_wdata),
    .raddr (raddr),
    .rdata (targ_rdata)
  );

  pfe_ram #(
    .WIDTH (pfe_pkg::COLOR_W),
    .DEPTH (pfe_pkg::PALETTE_ENTRIES)
  ) u_disp_ram (
    .clk   (clk),
    .we    (disp_we),
    .waddr (waddr),
    .wdata (disp_wdata),
    .raddr (raddr),
    .rdata (disp_rdata)
  );

  pfe_step u_step (
    .op   (op_q),
    .disp (disp_rdata),
    .targ (targ_rdata),
    .res  (step_res)
  );

  // Read address: the addressed entry on a transfer, else the sweep position
  assign raddr = accept ? pfe_pkg::ADDR_W'(in_idx) : sweep_addr;

  // Select the write source: clearing pass, sweep write-back, or a single write
  always_comb begin
    targ_we    = 1'b0;
    disp_we    = 1'b0;
    waddr      = proc_addr;
    targ_wdata = step_res.targ;
    disp_wdata = step_res.disp;
    if (state == ST_CLEAR) begin
      targ_we    = 1'b1;
      disp_we    = 1'b1;
      waddr      = clr_addr;
      targ_wdata = '0;
      disp_wdata = '0;
    end else if (proc_v) begin
      targ_we = 1'b1;
      disp_we = 1'b1;
    end else if (accept && in_ok) begin
      waddr      = pfe_pkg::ADDR_W'(in_idx);
      targ_wdata = in_color;
      disp_wdata = in_color;
      case (in_op)
        pfe_pkg::OP_WR_TARGET: targ_we = 1'b1;
        pfe_pkg::OP_WR_GAMMA: begin
          targ_we    = 1'b1;
          targ_wdata = in_gamma;
        end
        pfe_pkg::OP_WR_DISP: disp_we = 1'b1;
        default: ;
      endcase
    end
  end

  // Sequence one operation
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      proc_v   <= 1'b0;
      m_tvalid <= 1'b0;
      done_flag <= 1'b0;
    end else begin
      proc_v <= (state == ST_SWEEP);
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST_ADDR) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            case (in_op) inside
              pfe_pkg::OP_RD_TARGET, pfe_pkg::OP_RD_DISP: state <= ST_RDWAIT;
              pfe_pkg::OP_FADE, pfe_pkg::OP_BLACK, pfe_pkg::OP_COPY: state <= ST_SWEEP;
              default: state <= ST_FINISH;
            endcase
          end
        end
        ST_SWEEP: begin
          if (sweep_addr == LAST_ADDR) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN:  state <= ST_FINISH;
        ST_RDWAIT: state <= ST_FINISH;
        ST_FINISH: begin
          if (out_load) begin
            state     <= ST_IDLE;
            done_flag <= query_q ? 1'b0 : done_now;
          end
        end
        default: state <= ST_CLEAR;
      endcase
    end
  end

  // Hold the item, advance the sweep, gather counts and load the result
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q        <= in_op;
      query_q     <= in_query;
      ok_q        <= in_ok;
      sweep_addr  <= '0;
      changed_cnt <= '0;
      all_settled <= 1'b1;
      rd_data     <= '0;
    end else if (state == ST_SWEEP) begin
      sweep_addr <= sweep_addr + 1'b1;
    end
    proc_addr <= sweep_addr;
    if (proc_v) begin
      if (step_res.moved && (changed_cnt != '1)) begin
        changed_cnt <= changed_cnt + 1'b1;
      end
      all_settled <= all_settled && step_res.settled;
    end
    if (state == ST_RDWAIT) begin
      if (ok_q) begin
        rd_data <= (op_q == pfe_pkg::OP_RD_TARGET) ? targ_rdata : disp_rdata;
      end
    end
    if (out_load) begin
      out_rgb  <= rd_data;
      out_cnt  <= changed_cnt;
      out_done <= done_now;
    end
  end

  assign m_tdata = {4'b0000, out_done, out_cnt, out_rgb};

  // Sweep write-back never runs outside a tick or copy
  a_no_proc_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE || state == ST_FINISH || state == ST_CLEAR) |-> !proc_v)
    else $error("sweep write-back outside a sweep");

  // Changed count never exceeds the number of entries when a result is due
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH) |-> (int'(changed_cnt) <= pfe_pkg::PALETTE_ENTRIES))
    else $error("changed count out of range");

  // Loading a result presents it and returns to idle
  a_finish_load: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (m_tvalid && state == ST_IDLE))
    else $error("result load did not complete");

endmodule

>>> sim/palette_fade_engine_top_test.sv
`timescale 1ns / 100ps

module palette_fade_engine_top_test;

  typedef struct packed {
    pfe_pkg::op_t    op;
    logic            query;
    logic [7:0]      idx;
    logic [2:0][5:0] comp;   // red, green, blue from index 0
  } pal_cmd_t;

  typedef struct packed {
    logic [5:0] r;
    logic [5:0] g;
    logic [5:0] b;
    logic [8:0] changed;
    logic       done;
  } pal_reply_t;

  typedef struct packed {
    pal_cmd_t   cmd;
    logic       typed;
    pal_reply_t want;
  } pal_row_t;

  localparam int PLAN_ROWS = 22;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;    // entry_index[7:0], red_in[13:8], green_in[19:14], blue_in[25:20]
  logic [3:0]  s_tuser;    // mode[2:0], query_done[3]
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;    // red[5:0], green[11:6], blue[17:12], changed[26:18], done[27]

  // Shadow state of both palettes and the done flag
  logic [5:0]  tgt_pal  [pfe_pkg::PALETTE_ENTRIES][3];
  logic [5:0]  disp_pal [pfe_pkg::PALETTE_ENTRIES][3];
  logic        done_now;

  logic [5:0]  gamma_curve [64] = '{
    6'd0,  6'd10, 6'd14, 6'd17, 6'd19, 6'd21, 6'd23, 6'd24,
    6'd26, 6'd27, 6'd28, 6'd29, 6'd31, 6'd32, 6'd33, 6'd34,
    6'd35, 6'd36, 6'd37, 6'd37, 6'd38, 6'd39, 6'd40, 6'd41,
    6'd41, 6'd42, 6'd43, 6'd44, 6'd44, 6'd45, 6'd46, 6'd46,
    6'd47, 6'd48, 6'd48, 6'd49, 6'd49, 6'd50, 6'd51, 6'd51,
    6'd52, 6'd52, 6'd53, 6'd53, 6'd54, 6'd54, 6'd55, 6'd55,
    6'd56, 6'd56, 6'd57, 6'd57, 6'd58, 6'd58, 6'd59, 6'd59,
    6'd60, 6'd60, 6'd61, 6'd61, 6'd62, 6'd62, 6'd63, 6'd63
  };

  pal_reply_t  queued_replies [$];
  pal_row_t    plan [PLAN_ROWS];
  pal_reply_t  got_reply;
  pal_reply_t  want_reply;
  int          n_sent;
  int          n_replies;
  int          n_fail;
  bit          tight;
  bit          held_long;

  palette_fade_engine_top uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #6 clk = ~clk;

  // Apply one operation to the shadow palettes and return its reply
  function automatic pal_reply_t apply_palette_op(pal_cmd_t cmd);
    pal_reply_t res;
    int         changed;
    int         settled;
    bit         moved;
    logic [5:0] d;
    logic [5:0] t;
    logic [5:0] v;
    res     = '0;
    changed = 0;
    settled = 0;
    case (cmd.op) inside
      pfe_pkg::OP_WR_TARGET, pfe_pkg::OP_WR_GAMMA, pfe_pkg::OP_WR_DISP: begin
        if (int'(cmd.idx) < pfe_pkg::PALETTE_ENTRIES) begin
          for (int c = 0; c < 3; c++) begin
            v = (cmd.op == pfe_pkg::OP_WR_GAMMA) ? gamma_curve[cmd.comp[c]] : cmd.comp[c];
            if (cmd.op == pfe_pkg::OP_WR_DISP) disp_pal[cmd.idx][c] = v;
            else tgt_pal[cmd.idx][c] = v;
          end
        end
      end
      pfe_pkg::OP_RD_TARGET, pfe_pkg::OP_RD_DISP: begin
        if (int'(cmd.idx) < pfe_pkg::PALETTE_ENTRIES) begin
          if (cmd.op == pfe_pkg::OP_RD_TARGET) begin
            res.r = tgt_pal[cmd.idx][0];
            res.g = tgt_pal[cmd.idx][1];
            res.b = tgt_pal[cmd.idx][2];
          end else begin
            res.r = disp_pal[cmd.idx][0];
            res.g = disp_pal[cmd.idx][1];
            res.b = disp_pal[cmd.idx][2];
          end
        end
      end
      pfe_pkg::OP_FADE, pfe_pkg::OP_BLACK: begin
        done_now = 1'b0;
        for (int i = 0; i < pfe_pkg::PALETTE_ENTRIES; i++) begin
          moved = 1'b0;
          for (int c = 0; c < 3; c++) begin
            d = disp_pal[i][c];
            t = tgt_pal[i][c];
            if (cmd.op == pfe_pkg::OP_FADE && d != t) begin
              disp_pal[i][c] = (d < t) ? d + 6'd1 : d - 6'd1;
              moved = 1'b1;
            end else if (cmd.op == pfe_pkg::OP_BLACK && d != 6'd0) begin
              disp_pal[i][c] = d - 6'd1;
              tgt_pal[i][c]  = d - 6'd1;
              moved = 1'b1;
            end else begin
              settled++;
            end
          end
          if (moved) changed++;
        end
        if (settled == 3 * pfe_pkg::PALETTE_ENTRIES) done_now = 1'b1;
      end
      default: begin
        for (int i = 0; i < pfe_pkg::PALETTE_ENTRIES; i++) begin
          moved = 1'b0;
          for (int c = 0; c < 3; c++) begin
            if (disp_pal[i][c] != tgt_pal[i][c]) moved = 1'b1;
            disp_pal[i][c] = tgt_pal[i][c];
          end
          if (moved) changed++;
        end
      end
    endcase
    res.changed = (changed > 511) ? 9'd511 : 9'(changed);
    res.done    = done_now;
    if (cmd.query) done_now = 1'b0;
    return res;
  endfunction

  function automatic bit palettes_settled();
    for (int i = 0; i < pfe_pkg::PALETTE_ENTRIES; i++)
      for (int c = 0; c < 3; c++)
        if (disp_pal[i][c] != tgt_pal[i][c]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic bit display_dark();
    for (int i = 0; i < pfe_pkg::PALETTE_ENTRIES; i++)
      for (int c = 0; c < 3; c++)
        if (disp_pal[i][c] != 6'd0) return 1'b0;
    return 1'b1;
  endfunction

  function automatic pal_row_t plan_row(pfe_pkg::op_t op, bit q, int idx, int r, int g,
                                        int b, bit typed, int xr, int xg, int xb,
                                        int xchg, bit xdone);
    pal_row_t row;
    row.cmd.op       = op;
    row.cmd.query    = q;
    row.cmd.idx      = 8'(idx);
    row.cmd.comp[0]  = 6'(r);
    row.cmd.comp[1]  = 6'(g);
    row.cmd.comp[2]  = 6'(b);
    row.typed        = typed;
    row.want.r       = 6'(xr);
    row.want.g       = 6'(xg);
    row.want.b       = 6'(xb);
    row.want.changed = 9'(xchg);
    row.want.done    = xdone;
    return row;
  endfunction

  function automatic pal_cmd_t rand_cmd(pfe_pkg::op_t op);
    pal_cmd_t cmd;
    cmd.op      = op;
    cmd.query   = ($urandom_range(0, 3) == 0);
    cmd.idx     = 8'($urandom_range(0, 255));
    cmd.comp[0] = 6'($urandom_range(0, 63));
    cmd.comp[1] = 6'($urandom_range(0, 63));
    cmd.comp[2] = 6'($urandom_range(0, 63));
    return cmd;
  endfunction

  // Mostly short gaps, a few long ones, none during a tight stretch
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (tight || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one command, hold until the transfer, then log its reply
  task automatic send_cmd(input pal_cmd_t cmd, input bit typed, input pal_reply_t want);
    pal_reply_t pred;
    int         gap;
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, cmd.comp[2], cmd.comp[1], cmd.comp[0], cmd.idx};
    s_tuser  <= {cmd.query, cmd.op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pred = apply_palette_op(cmd);
    queued_replies.push_back(typed ? want : pred);
    n_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random(input pfe_pkg::op_t op);
    send_cmd(rand_cmd(op), 1'b0, '0);
  endtask

  // Stop offering until every reply is back
  task automatic drain_replies();
    s_tvalid <= 1'b0;
    while (queued_replies.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: reply %0d %s expected %0d, got %0d", $time, n_replies, name, want, got);
      n_fail++;
    end
  endtask

  // Stimulus: directed table, then random scenarios
  initial begin
    pal_cmd_t cmd;
    int       pick;
    int       k;
    int       n;
    int       lo;
    int       hi;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= '0;
    n_sent   = 0;
    tight    = 1'b0;
    done_now = 1'b0;
    for (int i = 0; i < pfe_pkg::PALETTE_ENTRIES; i++)
      for (int c = 0; c < 3; c++) begin
        tgt_pal[i][c]  = '0;
        disp_pal[i][c] = '0;
      end

    // Cleared palettes read zero; ticks on them find nothing to do
    plan[0]  = plan_row(pfe_pkg::OP_RD_TARGET, 0,   0,  0,  0,  0, 1,  0,  0,  0, 0, 0);
    plan[1]  = plan_row(pfe_pkg::OP_RD_DISP,   0, 255,  0,  0,  0, 1,  0,  0,  0, 0, 0);
    plan[2]  = plan_row(pfe_pkg::OP_FADE,      0,   0,  0,  0,  0, 1,  0,  0,  0, 0, 1);
    plan[3]  = plan_row(pfe_pkg::OP_BLACK,     1,   0,  0,  0,  0, 1,  0,  0,  0, 0, 1);
    plan[4]  = plan_row(pfe_pkg::OP_RD_TARGET, 1,   0,  0,  0,  0, 1,  0,  0,  0, 0, 0);
    // Extremes of the write fields and the gamma curve ends
    plan[5]  = plan_row(pfe_pkg::OP_WR_TARGET, 0,   0, 63, 63, 63, 1,  0,  0,  0, 0, 0);
    plan[6]  = plan_row(pfe_pkg::OP_WR_GAMMA,  0, 255,  1, 63,  0, 1,  0,  0,  0, 0, 0);
    plan[7]  = plan_row(pfe_pkg::OP_RD_TARGET, 0, 255,  0,  0,  0, 1, 10, 63,  0, 0, 0);
    plan[8]  = plan_row(pfe_pkg::OP_RD_TARGET, 0,   0,  0,  0,  0, 1, 63, 63, 63, 0, 0);
    plan[9]  = plan_row(pfe_pkg::OP_WR_DISP,   0, 128, 63,  0, 63, 1,  0,  0,  0, 0, 0);
    plan[10] = plan_row(pfe_pkg::OP_RD_DISP,   0, 128,  0,  0,  0, 1, 63,  0, 63, 0, 0);
    // Sweeps over a mixed palette
    plan[11] = plan_row(pfe_pkg::OP_FADE,      0,   0,  0,  0,  0, 0,  0,  0,  0, 0, 0);
    plan[12] = plan_row(pfe_pkg::OP_COPY,      0,   0,  0,  0,  0, 0,  0,  0,  0, 0, 0);
    plan[13] = plan_row(pfe_pkg::OP_FADE,      1,   0,  0,  0,  0, 0,  0,  0,  0, 0, 0);
    plan[14] = plan_row(pfe_pkg::OP_RD_DISP,   0,   0,  0,  0,  0, 0,  0,  0,  0, 0, 0);
    plan[15] = plan_row(pfe_pkg::OP_WR_DISP,   0,   7,  0,  0,  1, 0,  0,  0,  0, 0, 0);
    plan[16] = plan_row(pfe_pkg::OP_BLACK,     0,   0,  0,  0,  0, 0,  0,  0,  0, 0, 0);
    plan[17] = plan_row(pfe_pkg::OP_WR_GAMMA,  0,   1,  0, 32, 62, 0,  0,  0,  0, 0, 0);
    plan[18] = plan_row(pfe_pkg::OP_COPY,      1,  85, 42, 21, 63, 0,  0,  0,  0, 0, 0);
    plan[19] = plan_row(pfe_pkg::OP_BLACK,     0, 170, 21, 42,  0, 0,  0,  0,  0, 0, 0);
    plan[20] = plan_row(pfe_pkg::OP_RD_TARGET, 0,   0,  0,  0,  0, 0,  0,  0,  0, 0, 0);
    plan[21] = plan_row(pfe_pkg::OP_RD_TARGET, 1,   1,  0,  0,  0, 0,  0,  0,  0, 0, 0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < PLAN_ROWS; i++)
      send_cmd(plan[i].cmd, plan[i].typed, plan[i].want);
    drain_replies();

    while (n_sent < 520) begin
      tight = ($urandom_range(0, 3) == 0);
      pick  = $urandom_range(0, 19);
      if (pick < 9) begin
        // Burst of writes and reads with random content
        k = $urandom_range(4, 12);
        repeat (k)
          send_random(pfe_pkg::op_t'($urandom_range(pfe_pkg::OP_WR_TARGET,
                                                    pfe_pkg::OP_RD_DISP)));
      end else if (pick < 14) begin
        // Align, nudge a few targets, then fade until done shows
        send_random(pfe_pkg::OP_COPY);
        k = $urandom_range(1, 4);
        repeat (k) begin
          if ($urandom_range(0, 3) == 0) begin
            send_random(pfe_pkg::OP_WR_GAMMA);
          end else begin
            cmd = rand_cmd(pfe_pkg::OP_WR_TARGET);
            for (int c = 0; c < 3; c++) begin
              lo = (disp_pal[cmd.idx][c] > 6) ? disp_pal[cmd.idx][c] - 6 : 0;
              hi = (disp_pal[cmd.idx][c] < 57) ? disp_pal[cmd.idx][c] + 6 : 63;
              cmd.comp[c] = 6'($urandom_range(hi, lo));
            end
            send_cmd(cmd, 1'b0, '0);
          end
        end
        n = 0;
        while (!palettes_settled() && n < 70) begin
          send_random(pfe_pkg::OP_FADE);
          n++;
        end
        send_random(pfe_pkg::OP_FADE);
        if ($urandom_range(0, 1) == 0) send_random(pfe_pkg::OP_RD_DISP);
      end else if (pick < 17) begin
        // Dim a few entries, then black ticks toward dark
        k = $urandom_range(0, 3);
        repeat (k) begin
          cmd = rand_cmd(pfe_pkg::OP_WR_DISP);
          for (int c = 0; c < 3; c++) cmd.comp[c] = 6'($urandom_range(0, 4));
          send_cmd(cmd, 1'b0, '0);
        end
        n = 0;
        while (!display_dark() && n < 12) begin
          send_random(pfe_pkg::OP_BLACK);
          n++;
        end
        if (display_dark()) send_random(pfe_pkg::OP_BLACK);
      end else if (pick < 19) begin
        send_random(pfe_pkg::op_t'($urandom_range(0, 7)));
      end else begin
        drain_replies();
      end
    end

    s_tvalid <= 1'b0;
    while (queued_replies.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (n_fail == 0 && queued_replies.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Receiver readiness: open stretches, random stalls, one long hold-off
  initial begin
    int len;
    m_tready  <= 1'b0;
    held_long = 1'b0;
    forever begin
      if (!held_long && n_replies >= 60) begin
        held_long = 1'b1;
        m_tready <= 1'b0;
        repeat (1500) @(posedge clk);
      end else begin
        case ($urandom_range(0, 9)) inside
          0, 1, 2, 3: begin
            m_tready <= 1'b1;
            len = $urandom_range(10, 80);
            repeat (len) @(posedge clk);
          end
          4, 5, 6, 7: begin
            len = $urandom_range(1, 30);
            repeat (len) begin
              m_tready <= ($urandom_range(0, 2) != 0);
              @(posedge clk);
            end
          end
          8: begin
            m_tready <= 1'b0;
            len = $urandom_range(1, 4);
            repeat (len) @(posedge clk);
          end
          default: begin
            m_tready <= 1'b0;
            len = $urandom_range(20, 60);
            repeat (len) @(posedge clk);
          end
        endcase
      end
    end
  end

  // Compare each reply transfer with the oldest prediction
  initial begin
    n_replies = 0;
    n_fail    = 0;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_reply.r       = m_tdata[5:0];
      got_reply.g       = m_tdata[11:6];
      got_reply.b       = m_tdata[17:12];
      got_reply.changed = m_tdata[26:18];
      got_reply.done    = m_tdata[27];
      if (queued_replies.size() == 0) begin
        $display("%0t: unexpected reply, expected none, got %h", $time, m_tdata);
        n_fail++;
      end else begin
        want_reply = queued_replies.pop_front();
        check_field("red_out", want_reply.r, got_reply.r);
        check_field("green_out", want_reply.g, got_reply.g);
        check_field("blue_out", want_reply.b, got_reply.b);
        check_field("changed_entries", want_reply.changed, got_reply.changed);
        check_field("fade_done", want_reply.done, got_reply.done);
      end
      n_replies++;
    end
  end

  // Hard stop well past the slowest legal run
  initial begin
    #14_400_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
